@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 4;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

    // derived widths
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int NCOL_W = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CELL_W = 16;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int RA_W   = 11;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;

    // stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // reset attribute: white on black
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;

    // next tab stop for each column
    typedef logic [NCOL_W-1:0] tab_tbl_t [COLUMNS];

    function automatic tab_tbl_t build_tab_tbl();
        tab_tbl_t tbl;
        for (int i = 0; i < COLUMNS; i++)
        begin
            tbl[i] = NCOL_W'((i / TAB_STOP + 1) * TAB_STOP);
        end
        return tbl;
    endfunction

    localparam tab_tbl_t TAB_NEXT = build_tab_tbl();

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input transaction
        logic exec;     // run the put / clear / read step
        logic cnt_clr;  // zero the sweep counter
        logic cnt_inc;  // advance the sweep counter
        logic copy;     // one step of the row move
        logic blank;    // blank the cell at the counter
        logic rd_cap;   // hold the read data for a late result
        logic emit;     // load the result register
        logic sel_rd;   // result cell comes straight from the memory
    } tcw_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scroll;    // current put runs past the last row
        logic            in_range;  // read address inside the screen
        logic            copy_end;  // counter at the end of the row move
        logic            cnt_last;  // counter at the last cell
        logic            out_free;  // result register can take a value
    } tcw_status_t;

endpackage

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire                         clk,
    input  wire                         we,
    input  wire  [$clog2(DEPTH)-1:0]    waddr,
    input  wire  [WIDTH-1:0]            wdata,
    input  wire  [$clog2(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences accept, execute, read wait, row move, bottom row
// blanking, full clear and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_RWAIT = 7'b0000100,
        S_COPY  = 7'b0001000,
        S_BLANK = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.op == tcw_pkg::OP_PUT && status.scroll)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_COPY;
                end
                else if (status.op == tcw_pkg::OP_CLEAR)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_CLEAR;
                end
                else if (status.op == tcw_pkg::OP_READ && status.in_range)
                begin
                    state_next = S_RWAIT;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RWAIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel_rd = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_cap = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_COPY:
            begin
                cmd.copy = 1'b1;
                if (status.copy_end)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_BLANK, S_CLEAR:
            begin
                cmd.blank = 1'b1;
                if (!status.cnt_last)
                begin
                    cmd.cnt_inc = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath: item capture, cursor update, cell memory with its address and
// data selection, sweep counter, attribute register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire  [tcw_pkg::S_DATA_W-1:0]         s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]         m_axis_tdata,
    input  wire                                  cfg_wr_en,
    input  wire  [tcw_pkg::ATTR_W-1:0]           cfg_wr_data,
    input  tcw_pkg::tcw_cmd_t                    cmd,
    output tcw_pkg::tcw_status_t                 status
);

    localparam int AW = tcw_pkg::ADDR_W;

    // captured transaction
    logic [tcw_pkg::OP_W-1:0]   op_reg;
    logic [tcw_pkg::CHAR_W-1:0] ch_reg;
    logic [tcw_pkg::RA_W-1:0]   ra_reg;

    // cursor, attribute, counter
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic [AW-1:0]              cnt_reg, cnt_next;
    logic                       scrolled_reg;
    logic [tcw_pkg::CELL_W-1:0] cell_reg;

    // result register
    logic                       out_valid_reg;
    logic [tcw_pkg::POS_W-1:0]  out_pos_reg;
    logic [tcw_pkg::CELL_W-1:0] out_cell_reg;
    logic                       out_scr_reg;

    // put decode
    logic                        is_put;
    logic                        is_nl, is_tab, is_cr, is_bs;
    logic                        col_zero;
    logic [tcw_pkg::NCOL_W-1:0]  ncol;
    logic                        wrap;
    logic                        adv;
    logic                        last_row;
    logic                        scroll;
    logic                        put_we;
    logic [tcw_pkg::COL_W-1:0]   wcol;
    logic [AW-1:0]               put_addr;
    logic [tcw_pkg::POS_W-1:0]   pos;

    // memory ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
    logic [AW:0]                 copy_src;
    logic [tcw_pkg::CELL_W-1:0]  blank_cell;
    logic                        cnt_nz;

    assign blank_cell = {attr_reg, tcw_pkg::CH_BLANK};

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= s_axis_tdata[1:0];
            ch_reg <= s_axis_tdata[9:2];
            ra_reg <= s_axis_tdata[20:10];
        end
    end

    // put decode and next cursor
    always_comb
    begin
        is_put   = (op_reg == tcw_pkg::OP_PUT);
        is_nl    = (ch_reg == tcw_pkg::CH_NL);
        is_tab   = (ch_reg == tcw_pkg::CH_TAB);
        is_cr    = (ch_reg == tcw_pkg::CH_CR);
        is_bs    = (ch_reg == tcw_pkg::CH_BS);
        col_zero = (col_reg == '0);
        if (is_nl || is_cr)
        begin
            ncol = '0;
        end
        else if (is_tab)
        begin
            ncol = tcw_pkg::TAB_NEXT[col_reg];
        end
        else if (is_bs)
        begin
            ncol = col_zero ? tcw_pkg::NCOL_W'(col_reg)
                            : tcw_pkg::NCOL_W'(col_reg) - tcw_pkg::NCOL_W'(1);
        end
        else
        begin
            ncol = tcw_pkg::NCOL_W'(col_reg) + tcw_pkg::NCOL_W'(1);
        end
        wrap     = (ncol >= tcw_pkg::NCOL_W'(tcw_pkg::COLUMNS));
        adv      = is_nl || wrap;
        last_row = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
        scroll   = adv && last_row;
        put_we   = !(is_nl || is_tab || is_cr) && !(is_bs && col_zero);
        wcol     = is_bs ? col_reg - tcw_pkg::COL_W'(1) : col_reg;
        put_addr = AW'(row_reg) * AW'(tcw_pkg::COLUMNS) + AW'(wcol);
    end

    // cursor next value
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec && op_reg == tcw_pkg::OP_CLEAR)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.exec && is_put)
        begin
            col_next = wrap ? '0 : ncol[tcw_pkg::COL_W-1:0];
            if (adv && !last_row)
            begin
                row_next = row_reg + tcw_pkg::ROW_W'(1);
            end
        end
    end

    // cursor and attribute registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // sweep counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // scroll flag and held read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scrolled_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            scrolled_reg <= 1'b0;
        end
        else if (cmd.exec && is_put && scroll)
        begin
            scrolled_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cell_reg <= '0;
        end
        else if (cmd.rd_cap)
        begin
            cell_reg <= ram_rdata;
        end
    end

    // memory address and data selection
    always_comb
    begin
        cnt_nz    = (cnt_reg != '0);
        copy_src  = (AW + 1)'(cnt_reg) + (AW + 1)'(tcw_pkg::COLUMNS);
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = blank_cell;
        ram_raddr = ra_reg[AW-1:0];
        if (cmd.exec && is_put && put_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = put_addr;
            ram_wdata = {attr_reg, is_bs ? tcw_pkg::CH_BLANK : ch_reg};
        end
        else if (cmd.copy)
        begin
            ram_we    = cnt_nz;
            ram_waddr = cnt_reg - AW'(1);
            ram_wdata = ram_rdata;
            ram_raddr = status.copy_end ? '0 : copy_src[AW-1:0];
        end
        else if (cmd.blank)
        begin
            ram_we = 1'b1;
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status
    always_comb
    begin
        status.op       = op_reg;
        status.scroll   = scroll;
        status.in_range = (ra_reg < tcw_pkg::RA_W'(tcw_pkg::CELL_COUNT));
        status.copy_end = (cnt_reg == AW'(tcw_pkg::COPY_COUNT));
        status.cnt_last = (cnt_reg == AW'(tcw_pkg::CELL_COUNT - 1));
        status.out_free = !out_valid_reg || m_axis_tready;
    end

    // linear cursor after this step
    assign pos = tcw_pkg::POS_W'(tcw_pkg::POS_W'(row_next) * tcw_pkg::POS_W'(tcw_pkg::COLUMNS)
               + tcw_pkg::POS_W'(col_next));

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_pos_reg  <= pos;
            out_cell_reg <= cmd.sel_rd ? ram_rdata : cell_reg;
            out_scr_reg  <= scrolled_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_scr_reg, out_cell_reg, out_pos_reg};

endmodule

`default_nettype wire

@@ rtl/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine: 80x25 cell store, cursor, control codes,
// line wrap, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// A put or out-of-range read passes accept and execute before the result;
// an in-range read adds a read wait state. A put that scrolls moves rows
// 1..ROWS-1 up one row, then blanks the bottom row; clear blanks every cell.
// A new item is taken only once the last is through; the single memory
// write port sets the sweep lengths. Reset homes the cursor and sets the
// attribute to 0x0F; cell contents stay undefined until a clear.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top (
    input  wire                               clk,
    input  wire                               rst_n,
    // operation[1:0], char_code[9:2], read_address[20:10], zero fill
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [tcw_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // cursor_position[10:0], cell_value[26:11], scrolled[27], zero fill
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // color_attribute
    input  wire                               cfg_wr_en,
    input  wire  [tcw_pkg::ATTR_W-1:0]        cfg_wr_data
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;

    // controller
    tcw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // datapath
    tcw_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. A short table of directed
// transactions covers control codes, line wrap, scroll, clear, reads in and
// out of range and the unused operation. Random put-heavy traffic follows,
// with the attribute rewritten between phases. Every result is checked field
// by field against the table row or a cycle-free console model kept in the bench.
// ----------------------------------------------------------------------------

module tb_top;

    import tcw_pkg::*;

    // operation code left unused by the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int  PHASES      = 5;
    localparam int  PHASE_ITEMS = 60;
    localparam int  CYCLE_LIMIT = 6_000_000;
    localparam int  MAX_SHOWN   = 10;
    localparam int  DIR_COUNT   = 26;

    // one result transaction
    typedef struct packed {
        logic              scrolled;
        logic [CELL_W-1:0] cell_val;
        logic [POS_W-1:0]  pos;
    } report_t;

    // one directed row, repeated reps times
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [RA_W-1:0]   addr;
        logic [6:0]        reps;
        logic              known;
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cell_val;
        logic              scrolled;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [DIR_COUNT] = '{
        // out-of-range read and unused op right after reset
        '{OP_READ,   8'h00, 11'd2047, 7'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{OP_UNUSED, 8'hFF, 11'd2047, 7'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        // clear, then blanks at both ends of the store
        '{OP_CLEAR,  8'h00, 11'd0,    7'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{OP_READ,   8'h00, 11'd0,    7'd1,  1'b1, 11'd0,    16'h0F20, 1'b0},
        '{OP_READ,   8'h00, 11'd1999, 7'd1,  1'b1, 11'd0,    16'h0F20, 1'b0},
        // plain characters, code 0 and 0xff included
        '{OP_PUT,    8'h41, 11'd0,    7'd1,  1'b1, 11'd1,    16'h0000, 1'b0},
        '{OP_READ,   8'h00, 11'd0,    7'd1,  1'b1, 11'd1,    16'h0F41, 1'b0},
        '{OP_PUT,    8'h00, 11'd0,    7'd1,  1'b1, 11'd2,    16'h0000, 1'b0},
        '{OP_PUT,    8'hFF, 11'd0,    7'd1,  1'b1, 11'd3,    16'h0000, 1'b0},
        '{OP_READ,   8'h00, 11'd2,    7'd1,  1'b1, 11'd3,    16'h0FFF, 1'b0},
        // backspace erases to the left
        '{OP_PUT,    CH_BS, 11'd0,    7'd1,  1'b1, 11'd2,    16'h0000, 1'b0},
        '{OP_READ,   8'h00, 11'd2,    7'd1,  1'b1, 11'd2,    16'h0F20, 1'b0},
        // tab stops, carriage return, backspace at column 0, newline
        '{OP_PUT,    CH_TAB, 11'd0,   7'd1,  1'b1, 11'd4,    16'h0000, 1'b0},
        '{OP_PUT,    CH_TAB, 11'd0,   7'd1,  1'b1, 11'd8,    16'h0000, 1'b0},
        '{OP_PUT,    CH_CR, 11'd0,    7'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{OP_PUT,    CH_BS, 11'd0,    7'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{OP_PUT,    CH_NL, 11'd0,    7'd1,  1'b1, 11'd80,   16'h0000, 1'b0},
        '{OP_READ,   8'h00, 11'd2000, 7'd1,  1'b1, 11'd80,   16'h0000, 1'b0},
        // down to the last row, then newline past it
        '{OP_PUT,    CH_NL, 11'd0,    7'd23, 1'b0, 11'd0,    16'h0000, 1'b0},
        '{OP_PUT,    CH_NL, 11'd0,    7'd1,  1'b1, 11'd1920, 16'h0000, 1'b1},
        // line wrap on the last row scrolls
        '{OP_PUT,    8'h7E, 11'd0,    7'd79, 1'b0, 11'd0,    16'h0000, 1'b0},
        '{OP_PUT,    8'h7E, 11'd0,    7'd1,  1'b1, 11'd1920, 16'h0000, 1'b1},
        // tab past the line end on the last row scrolls
        '{OP_PUT,    8'h31, 11'd0,    7'd78, 1'b0, 11'd0,    16'h0000, 1'b0},
        '{OP_PUT,    CH_TAB, 11'd0,   7'd1,  1'b1, 11'd1920, 16'h0000, 1'b1},
        '{OP_READ,   8'h00, 11'd1917, 7'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
        '{OP_READ,   8'h00, 11'd1920, 7'd1,  1'b1, 11'd1920, 16'h0F20, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  cfg_wr_en;
    logic [ATTR_W-1:0]     cfg_wr_data;

    // console state as the bench sees it
    logic [CELL_W-1:0]     screen [CELL_COUNT];
    bit                    cell_written [CELL_COUNT];
    int                    cur_col;
    int                    cur_row;
    logic [ATTR_W-1:0]     attribute;

    report_t               console_reports [$];
    int                    mismatches;
    int                    idle_pct;
    longint                cycle_count;

    text_console_writer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("text_console_writer_top: mismatch");
            $finish;
        end
    end

    // blank a span of the console with the current attribute
    task automatic blank_span(input int from, input int upto);
        for (int i = from; i < upto; i++)
        begin
            screen[i]       = {attribute, CH_BLANK};
            cell_written[i] = 1'b1;
        end
    endtask

    // apply one operation to the console and return its report
    task automatic apply_console_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                    input logic [RA_W-1:0] addr, output report_t rep);
        rep = '0;
        if (op == OP_PUT)
        begin
            if (ch == CH_NL)
            begin
                cur_col = 0;
                cur_row++;
            end
            else if (ch == CH_TAB)
                cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
            else if (ch == CH_CR)
                cur_col = 0;
            else if (ch == CH_BS)
            begin
                if (cur_col > 0)
                begin
                    cur_col--;
                    blank_span(cur_row * COLUMNS + cur_col, cur_row * COLUMNS + cur_col + 1);
                end
            end
            else
            begin
                screen[cur_row * COLUMNS + cur_col]       = {attribute, ch};
                cell_written[cur_row * COLUMNS + cur_col] = 1'b1;
                cur_col++;
            end
            // line wrap
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                cur_row++;
            end
            // scroll up one row
            if (cur_row >= ROWS)
            begin
                for (int i = 0; i < COPY_COUNT; i++)
                begin
                    screen[i]       = screen[i + COLUMNS];
                    cell_written[i] = cell_written[i + COLUMNS];
                end
                blank_span(COPY_COUNT, CELL_COUNT);
                cur_row      = ROWS - 1;
                rep.scrolled = 1'b1;
            end
        end
        else if (op == OP_CLEAR)
        begin
            blank_span(0, CELL_COUNT);
            cur_col = 0;
            cur_row = 0;
        end
        else if (op == OP_READ)
        begin
            if (addr < CELL_COUNT)
                rep.cell_val = screen[addr];
        end
        rep.pos = POS_W'(cur_row * COLUMNS + cur_col);
    endtask

    // offer one transaction and hold it until accepted
    task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [RA_W-1:0] addr, input bit known, input report_t typed);
        report_t rep;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, addr, ch, op};
        do
            @(negedge clk);
        while (!s_axis_tready);
        apply_console_op(op, ch, addr, rep);
        console_reports.push_back(known ? typed : rep);
        @(posedge clk);
    endtask

    // wait for every outstanding report, then let the block settle
    task automatic wait_idle();
        while (console_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        attribute    = value;
    endtask

    // random operation, mostly puts, in-range reads only of written cells
    task automatic pick_random_op(output logic [OP_W-1:0] op, output logic [CHAR_W-1:0] ch,
                                  output logic [RA_W-1:0] addr);
        int sel;
        int here;
        sel  = $urandom_range(99);
        ch   = CHAR_W'($urandom_range(255));
        addr = RA_W'($urandom_range(2047));
        if (sel < 72)
        begin
            op  = OP_PUT;
            sel = $urandom_range(99);
            if (sel < 9)
                ch = CH_NL;
            else if (sel < 15)
                ch = CH_TAB;
            else if (sel < 19)
                ch = CH_CR;
            else if (sel < 27)
                ch = CH_BS;
        end
        else if (sel < 92)
        begin
            op   = OP_READ;
            here = cur_row * COLUMNS + cur_col;
            sel  = $urandom_range(99);
            if (sel < 12)
                addr = RA_W'($urandom_range(2047, CELL_COUNT));
            else if (sel < 55 && here >= 2)
                addr = RA_W'(here - $urandom_range(2, 0));
            else
                addr = RA_W'($urandom_range(CELL_COUNT - 1));
            // never touch a cell that holds nothing yet
            if (addr < CELL_COUNT && !cell_written[addr])
                addr = RA_W'(CELL_COUNT);
        end
        else if (sel < 96)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
    endtask

    // compare one accepted result with the oldest expectation
    task automatic check_report(input logic [M_DATA_W-1:0] data);
        report_t got;
        report_t want;
        got.pos      = data[POS_W-1:0];
        got.cell_val = data[POS_W+CELL_W-1:POS_W];
        got.scrolled = data[POS_W+CELL_W];
        if (console_reports.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("unexpected result: pos %0d cell %h scrolled %b",
                         got.pos, got.cell_val, got.scrolled);
        end
        else
        begin
            want = console_reports.pop_front();
            if (got.pos !== want.pos || got.cell_val !== want.cell_val
                || got.scrolled !== want.scrolled)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("result differs: pos %0d/%0d cell %h/%h scrolled %b/%b (exp/act)",
                             want.pos, got.pos, want.cell_val, got.cell_val,
                             want.scrolled, got.scrolled);
            end
        end
    endtask

    // result side: random back-pressure, check on each transaction
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
        end
    end

    // stimulus
    initial
    begin
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [RA_W-1:0]   addr;
        report_t           typed;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        cycle_count   <= 0;
        mismatches     = 0;
        idle_pct       = 34;
        cur_col        = 0;
        cur_row        = 0;
        attribute      = ATTR_RESET;
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            screen[i]       = '0;
            cell_written[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_COUNT; r++)
        begin
            typed.pos      = DIRECTED_ROWS[r].pos;
            typed.cell_val = DIRECTED_ROWS[r].cell_val;
            typed.scrolled = DIRECTED_ROWS[r].scrolled;
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_op(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].addr,
                        DIRECTED_ROWS[r].known, typed);
        end

        // random phases, each under its own attribute
        for (int p = 0; p < PHASES; p++)
        begin
            s_axis_tvalid <= 1'b0;
            wait_idle();
            case (p)
                0:       write_attribute(8'h00);
                1:       write_attribute(8'hFF);
                3:       write_attribute(8'hA5);
                default: write_attribute(ATTR_W'($urandom_range(254, 1)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // back-to-back stretch in the middle phase
                idle_pct = (p == 2) ? 0 : 34;
                pick_random_op(op, ch, addr);
                send_op(op, ch, addr, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        idle_pct       = 34;

        // drain and finish
        while (console_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && console_reports.size() == 0)
            $display("text_console_writer_top: match");
        else
            $display("text_console_writer_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer_top.sv
verif/tb_top.sv
